### design/rtd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtd_pkg
// Shared types, constants and the CORDIC arctangent table for the tilt
// displacement block.
// ----------------------------------------------------------------------------
package rtd_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;
  localparam int CW                = 34;  // CORDIC x/y width, Q2.30 plus headroom
  localparam int ZW                = 32;  // CORDIC angle width, Q11.20 degrees
  localparam int VW                = 33;  // feature vector component width
  localparam int KW                = 16;  // axis component width

  localparam logic signed [CW-1:0] GAIN_Q30  = 34'sd652032874;
  localparam logic signed [16:0]   NINETY_Q8 = 17'sd23040;

  typedef enum logic [2:0] {
    REG_CENTRE_X = 3'd0,
    REG_CENTRE_Y = 3'd1,
    REG_AXIS_A_X = 3'd2,
    REG_AXIS_A_Y = 3'd3,
    REG_AXIS_A_Z = 3'd4,
    REG_AXIS_B_X = 3'd5,
    REG_AXIS_B_Y = 3'd6,
    REG_AXIS_B_Z = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [KW-1:0] k0;
    logic signed [KW-1:0] k1;
    logic signed [KW-1:0] k2;
  } vec_t;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
    vec_t                 vec;
  } cell_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] move_z;
    logic               saturated;
  } res_t;

  function automatic logic signed [ZW-1:0] atan_q20(input int idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:  a = 32'sd47185920;
      1:  a = 32'sd27855475;
      2:  a = 32'sd14718068;
      3:  a = 32'sd7471121;
      4:  a = 32'sd3750058;
      5:  a = 32'sd1876857;
      6:  a = 32'sd938658;
      7:  a = 32'sd469357;
      8:  a = 32'sd234682;
      9:  a = 32'sd117342;
      10: a = 32'sd58671;
      11: a = 32'sd29335;
      12: a = 32'sd14668;
      13: a = 32'sd7334;
      14: a = 32'sd3667;
      15: a = 32'sd1833;
      16: a = 32'sd917;
      17: a = 32'sd458;
      18: a = 32'sd229;
      19: a = 32'sd115;
      20: a = 32'sd57;
      21: a = 32'sd29;
      22: a = 32'sd14;
      23: a = 32'sd7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

### design/rtd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtd_in_if / rtd_out_if
// Valid/ready channels for the position words and the displacement words.
// ----------------------------------------------------------------------------
interface rtd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] tilt_deg;
  logic               axis_pick;
  modport source (output valid, pos_x, pos_y, tilt_deg, axis_pick, input ready);
  modport sink   (input valid, pos_x, pos_y, tilt_deg, axis_pick, output ready);
endinterface

interface rtd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] move_x;
  logic signed [31:0] move_y;
  logic signed [31:0] move_z;
  logic               saturated;
  modport source (output valid, move_x, move_y, move_z, saturated, input ready);
  modport sink   (input valid, move_x, move_y, move_z, saturated, output ready);
endinterface
`default_nettype wire

### design/rtd_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtd_cell
// One CORDIC rotation stage; carries the feature vector along with it.
// ----------------------------------------------------------------------------
module rtd_cell
  import rtd_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        adv,
  input  wire cell_t cell_in,
  output cell_t      cell_out
);

  cell_t cell_r, cell_nxt;

  always_comb begin
    cell_nxt = cell_in;
    if (cell_in.z >= 0) begin
      cell_nxt.x = cell_in.x - (cell_in.y >>> IDX);
      cell_nxt.y = cell_in.y + (cell_in.x >>> IDX);
      cell_nxt.z = cell_in.z - atan_q20(IDX);
    end else begin
      cell_nxt.x = cell_in.x + (cell_in.y >>> IDX);
      cell_nxt.y = cell_in.y - (cell_in.x >>> IDX);
      cell_nxt.z = cell_in.z + atan_q20(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule
`default_nettype wire

### design/rtd_post.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtd_post
// Rodrigues terms after the CORDIC: cross and dot products, the k(v.k)
// term, the two products per axis, then rounding and saturation.
// ----------------------------------------------------------------------------
module rtd_post
  import rtd_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        adv,
  input  wire cell_t cell_in,
  output res_t       res
);

  // Stage 1: cos/sin rounding, cross and dot products.
  logic                 v1_r;
  vec_t                 vec1_r;
  logic signed [27:0]   cs1_r, sn1_r;
  logic signed [36:0]   c0_1_r, c1_1_r, c2_1_r, d_1_r;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] xr, yr;
  logic signed [50:0]   p0, p1, p2, pd;

  always_comb begin
    xs = cell_in.neg ? -cell_in.x : cell_in.x;
    xr = (xs + 34'sd32) >>> 6;
    yr = (cell_in.y + 34'sd32) >>> 6;
    p0 = 51'(cell_in.vec.vy) * 51'(cell_in.vec.k2);
    p1 = -(51'(cell_in.vec.vx) * 51'(cell_in.vec.k2));
    p2 = 51'(cell_in.vec.vx) * 51'(cell_in.vec.k1)
       - 51'(cell_in.vec.vy) * 51'(cell_in.vec.k0);
    pd = 51'(cell_in.vec.vx) * 51'(cell_in.vec.k0)
       + 51'(cell_in.vec.vy) * 51'(cell_in.vec.k1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r   <= cell_in.valid;
      vec1_r <= cell_in.vec;
      cs1_r  <= xr[27:0];
      sn1_r  <= yr[27:0];
      c0_1_r <= 37'((p0 + 51'sd8192) >>> 14);
      c1_1_r <= 37'((p1 + 51'sd8192) >>> 14);
      c2_1_r <= 37'((p2 + 51'sd8192) >>> 14);
      d_1_r  <= 37'((pd + 51'sd8192) >>> 14);
    end
  end

  // Stage 2: k times the dot product, and one minus cosine.
  logic               v2_r;
  logic signed [39:0] a0_2_r, a1_2_r, a2_2_r;
  logic signed [36:0] c0_2_r, c1_2_r, c2_2_r;
  logic signed [28:0] omc2_r;
  logic signed [27:0] sn2_r;
  logic signed [52:0] q0, q1, q2;
  logic signed [38:0] kd0, kd1, kd2;

  always_comb begin
    q0  = 53'(vec1_r.k0) * 53'(d_1_r);
    q1  = 53'(vec1_r.k1) * 53'(d_1_r);
    q2  = 53'(vec1_r.k2) * 53'(d_1_r);
    kd0 = 39'((q0 + 53'sd8192) >>> 14);
    kd1 = 39'((q1 + 53'sd8192) >>> 14);
    kd2 = 39'((q2 + 53'sd8192) >>> 14);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r   <= v1_r;
      // The v and k(v.k) terms share the (1 - cos) factor.
      a0_2_r <= 40'(vec1_r.vx) - 40'(kd0);
      a1_2_r <= 40'(vec1_r.vy) - 40'(kd1);
      a2_2_r <= -40'(kd2);
      c0_2_r <= c0_1_r;
      c1_2_r <= c1_1_r;
      c2_2_r <= c2_1_r;
      omc2_r <= 29'sd16777216 - 29'(cs1_r);
      sn2_r  <= sn1_r;
    end
  end

  // Stage 3: products.
  logic               v3_r;
  logic signed [68:0] m0_r, m1_r, m2_r;
  logic signed [64:0] n0_r, n1_r, n2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
      m0_r <= 69'(a0_2_r) * 69'(omc2_r);
      m1_r <= 69'(a1_2_r) * 69'(omc2_r);
      m2_r <= 69'(a2_2_r) * 69'(omc2_r);
      n0_r <= 65'(c0_2_r) * 65'(sn2_r);
      n1_r <= 65'(c1_2_r) * 65'(sn2_r);
      n2_r <= 65'(c2_2_r) * 65'(sn2_r);
    end
  end

  // Stage 4: round, saturate, output register.
  logic signed [70:0] s0, s1, s2;
  logic signed [46:0] r0, r1, r2;
  logic               o0, o1, o2;
  res_t               res_r, res_nxt;

  always_comb begin
    s0 = 71'(m0_r) - 71'(n0_r) + 71'sd8388608;
    s1 = 71'(m1_r) - 71'(n1_r) + 71'sd8388608;
    s2 = 71'(m2_r) - 71'(n2_r) + 71'sd8388608;
    r0 = 47'(s0 >>> 24);
    r1 = 47'(s1 >>> 24);
    r2 = 47'(s2 >>> 24);
    o0 = (r0 > 47'sd2147483647) || (r0 < -47'sd2147483648);
    o1 = (r1 > 47'sd2147483647) || (r1 < -47'sd2147483648);
    o2 = (r2 > 47'sd2147483647) || (r2 < -47'sd2147483648);
    res_nxt.valid     = v3_r;
    res_nxt.move_x    = o0 ? (r0[46] ? 32'sh80000000 : 32'sh7fffffff) : r0[31:0];
    res_nxt.move_y    = o1 ? (r1[46] ? 32'sh80000000 : 32'sh7fffffff) : r1[31:0];
    res_nxt.move_z    = o2 ? (r2[46] ? 32'sh80000000 : 32'sh7fffffff) : r2[31:0];
    res_nxt.saturated = o0 | o1 | o2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

### design/rodrigues_tilt_displacement.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rodrigues_tilt_displacement
// Displacement of a feature under a stage tilt, by Rodrigues' formula.
// ----------------------------------------------------------------------------
// Usage: a word on in_ch carries pos_x, pos_y (Q16.16), tilt_deg (Q7.8) and
// axis_pick; each accepted word yields one word on out_ch with move_x/y/z
// (Q16.16, saturated) and the saturated flag, in order.
// The cfg port writes the centre and the two axes; write only while idle.
// The pipeline is one input register, one CORDIC cell per stage, and four
// stages of products, rounding and saturation.
// Throughput is one word per cycle; the whole pipeline advances together.
// When the receiver stalls with a word on the output register, the pipeline
// holds and in_ch.ready drops until that word is taken.
// Reset clears all valid bits and loads the default centre (0,0) and axes
// a = (11585, 11585, 0) and b = (11585, -11585, 0).
// ----------------------------------------------------------------------------
module rodrigues_tilt_displacement
  import rtd_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  rtd_in_if.sink       in_ch,
  rtd_out_if.source    out_ch,
  input  wire          cfg_we,
  input  wire [2:0]    cfg_idx,
  input  wire [31:0]   cfg_data
);

  logic signed [31:0] centre_x_r, centre_y_r;
  logic signed [15:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r <= '0;
      centre_y_r <= '0;
      ax_r <= 16'sd11585;
      ay_r <= 16'sd11585;
      az_r <= '0;
      bx_r <= 16'sd11585;
      by_r <= -16'sd11585;
      bz_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_CENTRE_X: centre_x_r <= cfg_data;
        REG_CENTRE_Y: centre_y_r <= cfg_data;
        REG_AXIS_A_X: ax_r <= cfg_data[15:0];
        REG_AXIS_A_Y: ay_r <= cfg_data[15:0];
        REG_AXIS_A_Z: az_r <= cfg_data[15:0];
        REG_AXIS_B_X: bx_r <= cfg_data[15:0];
        REG_AXIS_B_Y: by_r <= cfg_data[15:0];
        REG_AXIS_B_Z: bz_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  res_t res;
  logic adv;

  assign adv          = !res.valid || out_ch.ready;
  assign in_ch.ready  = adv;

  // Input register: fold the angle into +/-90 degrees and form v.
  cell_t cells [0:CORDIC_STAGES];
  cell_t in_r, in_nxt;
  logic signed [16:0] t, tf;

  always_comb begin
    t           = 17'(in_ch.tilt_deg);
    in_nxt.neg  = 1'b0;
    tf          = t;
    if (t > NINETY_Q8) begin
      tf         = 17'sd46080 - t;
      in_nxt.neg = 1'b1;
    end else if (t < -NINETY_Q8) begin
      tf         = -17'sd46080 - t;
      in_nxt.neg = 1'b1;
    end
    in_nxt.valid  = in_ch.valid;
    in_nxt.x      = GAIN_Q30;
    in_nxt.y      = '0;
    in_nxt.z      = 32'(tf) <<< 12;
    in_nxt.vec.vx = 33'(centre_x_r) - 33'(in_ch.pos_x);
    in_nxt.vec.vy = 33'(centre_y_r) - 33'(in_ch.pos_y);
    in_nxt.vec.k0 = in_ch.axis_pick ? bx_r : ax_r;
    in_nxt.vec.k1 = in_ch.axis_pick ? by_r : ay_r;
    in_nxt.vec.k2 = in_ch.axis_pick ? bz_r : az_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r.valid <= 1'b0;
    end else if (adv) begin
      in_r <= in_nxt;
    end
  end

  assign cells[0] = in_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    rtd_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_in  (cells[g]),
      .cell_out (cells[g+1])
    );
  end

  rtd_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cell_in (cells[CORDIC_STAGES]),
    .res     (res)
  );

  assign out_ch.valid     = res.valid;
  assign out_ch.move_x    = res.move_x;
  assign out_ch.move_y    = res.move_y;
  assign out_ch.move_z    = res.move_z;
  assign out_ch.saturated = res.saturated;

endmodule
`default_nettype wire
